[rtl/core/kct_pkg.sv]
`timescale 1ns / 1ps

package kct_pkg;

   // Default table geometry.
   localparam int ENTRIES_DEF    = 64;
   localparam int KEY_BITS_DEF   = 64;
   localparam int COUNT_BITS_DEF = 31;

   // Fixed payload widths of the channels.
   localparam int KEY_W    = 64;
   localparam int AMOUNT_W = 31;
   localparam int STATUS_W = 3;
   localparam int OUT_CNT_W = 31;

   // Request codes.
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ENOUGH = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

   typedef struct packed {
      logic                req_type;
      logic [KEY_W-1:0]    item_key;
      logic [AMOUNT_W-1:0] amount;
   } kct_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [OUT_CNT_W-1:0] count_now;
      logic                 table_empty;
   } kct_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic scan;
      logic commit;
   } kct_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } kct_stat_type;

endpackage

[rtl/core/keyed_count_table.sv]
`timescale 1ns / 1ps
// Each request is latched, then every entry of the key memory is scanned through its
// single read port, one entry per cycle, and the update is then committed into the output
// register once it is free. A new request is taken only once the last one has been committed.
// Reset (synchronous, active high) clears all valid bits, the entry count, the
// controller and the output valid flag; the key and count memories are not cleared.

module keyed_count_table #(
   parameter int ENTRIES    = kct_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = kct_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kct_pkg::kct_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kct_pkg::kct_rsp_type rsp_payload
);

   // The controller sequences each request through three phases: it takes the
   // request transfer, scans every entry of the table looking for the key and
   // for the lowest free entry, and then applies the update once the output register is free.
   // The datapath holds the key and count memories, the valid bits, a running
   // count of valid entries (which gives the empty flag directly), and the
   // output register.
   kct_pkg::kct_cmd_type  cmd;
   kct_pkg::kct_stat_type stat;

   kct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The output register is separate from the scan, so a new request can be
   // taken while the previous result still waits for its transfer. The update
   // phase stalls only if that result is still held when the next one is ready.
   kct_datapath #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // A request transfer starts a scan, so the input side closes in the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a scan is in progress");

   // A result is only ever committed into a free output register.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("result committed over an untaken result");

   // A full table or a missing key leaves no count to report.
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == kct_pkg::ST_FULL ||
                     rsp_payload.status == kct_pkg::ST_NOT_FOUND))
      |-> (rsp_payload.count_now == '0))
      else $error("nonzero count with full or not-found status");

   // A saturating add always leaves at least one valid entry behind.
   a_insert_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == kct_pkg::ST_SATURATED) |-> !rsp_payload.table_empty)
      else $error("table reported empty after a saturating add");
`endif

endmodule

[rtl/core/kct_ctrl.sv]
`timescale 1ns / 1ps

module kct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kct_pkg::kct_stat_type stat,
   output kct_pkg::kct_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.scan     = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // Hold the result back until the output register can take it.
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/kct_datapath.sv]
`timescale 1ns / 1ps

module kct_datapath #(
   parameter int ENTRIES    = kct_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = kct_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kct_pkg::kct_req_type  req_payload,
   input  kct_pkg::kct_cmd_type  cmd,
   output kct_pkg::kct_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kct_pkg::kct_rsp_type  rsp_payload
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SCAN_BITS = IDX_BITS + 1;
   localparam int VCNT_BITS = $clog2(ENTRIES + 1);
   // Arithmetic width: wide enough for both a count and an amount.
   localparam int CW = (COUNT_BITS > kct_pkg::AMOUNT_W) ? COUNT_BITS : kct_pkg::AMOUNT_W;
   localparam logic [CW:0] CNT_MAX = ((CW + 1)'(1) << COUNT_BITS) - (CW + 1)'(1);
   localparam logic [SCAN_BITS-1:0] SCAN_END = SCAN_BITS'(ENTRIES);

   logic [KEY_BITS-1:0]   key_mem [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [VCNT_BITS-1:0]  vcount_ff;

   // Latched request.
   logic                          op_ff;
   logic [KEY_BITS-1:0]           key_ff;
   logic [kct_pkg::AMOUNT_W-1:0]  amt_ff;

   // Scan pipeline: address stage and compare stage.
   logic [SCAN_BITS-1:0]  scan_idx_ff;
   logic                  rd_pend_ff;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;

   logic                  hit_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff;
   logic [COUNT_BITS-1:0] hit_cnt_ff;
   logic                  free_ff;
   logic [IDX_BITS-1:0]   free_idx_ff;

   logic                  rsp_valid_ff;
   kct_pkg::kct_rsp_type  rsp_ff;

   logic                  rd_entry_valid;
   logic                  scan_rd;

   // Update logic.
   logic [CW:0]                   cnt_w;
   logic [CW:0]                   amt_w;
   logic [CW:0]                   sum_w;
   logic [CW:0]                   new_cnt;
   logic [kct_pkg::STATUS_W-1:0]  new_status;
   logic                          wr_key;
   logic                          wr_cnt;
   logic                          set_valid;
   logic                          clr_valid;
   logic [IDX_BITS-1:0]           wr_idx;
   logic [VCNT_BITS-1:0]          vcount_in;

   assign scan_rd = cmd.scan && (scan_idx_ff != SCAN_END);
   assign rd_entry_valid = valid_ff[rd_idx_ff];

   assign stat.scan_done = (scan_idx_ff == SCAN_END) && !rd_pend_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign cnt_w = (CW + 1)'(hit_cnt_ff);
   assign amt_w = (CW + 1)'(amt_ff);
   assign sum_w = cnt_w + amt_w;

   always_comb begin
      new_cnt    = '0;
      new_status = kct_pkg::ST_OK;
      wr_key     = 1'b0;
      wr_cnt     = 1'b0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      wr_idx     = hit_idx_ff;
      vcount_in  = vcount_ff;
      if (op_ff == kct_pkg::OP_ADD) begin
         priority if (hit_ff) begin
            wr_cnt = 1'b1;
            if (sum_w > CNT_MAX) begin
               new_cnt    = CNT_MAX;
               new_status = kct_pkg::ST_SATURATED;
            end else begin
               new_cnt = sum_w;
            end
         end else if (!free_ff) begin
            new_status = kct_pkg::ST_FULL;
         end else begin
            wr_key    = 1'b1;
            wr_cnt    = 1'b1;
            set_valid = 1'b1;
            wr_idx    = free_idx_ff;
            vcount_in = vcount_ff + VCNT_BITS'(1);
            if (amt_w > CNT_MAX) begin
               new_cnt    = CNT_MAX;
               new_status = kct_pkg::ST_SATURATED;
            end else begin
               new_cnt = amt_w;
            end
         end
      end else begin
         priority if (!hit_ff) begin
            new_status = kct_pkg::ST_NOT_FOUND;
         end else if (cnt_w < amt_w) begin
            new_status = kct_pkg::ST_NOT_ENOUGH;
            new_cnt    = cnt_w;
         end else if (cnt_w == amt_w) begin
            clr_valid = 1'b1;
            vcount_in = vcount_ff - VCNT_BITS'(1);
         end else begin
            wr_cnt  = 1'b1;
            new_cnt = cnt_w - amt_w;
         end
      end
   end

   // Key and count memories: one read port for the scan, one write port for the update.
   always_ff @(posedge clock) begin
      if (scan_rd) begin
         rd_key_ff <= key_mem[scan_idx_ff[IDX_BITS-1:0]];
         rd_cnt_ff <= cnt_mem[scan_idx_ff[IDX_BITS-1:0]];
      end
      if (cmd.commit && wr_key) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (cmd.commit && wr_cnt) begin
         cnt_mem[wr_idx] <= new_cnt[COUNT_BITS-1:0];
      end
   end

   // Request latch, scan bookkeeping and output payload.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_payload.req_type;
         key_ff <= req_payload.item_key[KEY_BITS-1:0];
         amt_ff <= req_payload.amount;
      end
      if (scan_rd) begin
         rd_idx_ff <= scan_idx_ff[IDX_BITS-1:0];
      end
      if (cmd.load_req) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         if (rd_entry_valid && !hit_ff && (rd_key_ff == key_ff)) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_cnt_ff <= rd_cnt_ff;
         end
         if (!rd_entry_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_ff.status      <= new_status;
         rsp_ff.count_now   <= new_cnt[kct_pkg::OUT_CNT_W-1:0];
         rsp_ff.table_empty <= (vcount_in == '0);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         vcount_ff    <= '0;
         scan_idx_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            scan_idx_ff <= '0;
         end else if (scan_rd) begin
            scan_idx_ff <= scan_idx_ff + SCAN_BITS'(1);
         end
         rd_pend_ff <= scan_rd;
         if (cmd.commit) begin
            vcount_ff <= vcount_in;
            if (set_valid) begin
               valid_ff[wr_idx] <= 1'b1;
            end
            if (clr_valid) begin
               valid_ff[wr_idx] <= 1'b0;
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[tb/sv/keyed_count_table_tb.sv]
`timescale 1ns / 1ps

module keyed_count_table_tb;
   import kct_pkg::*;

   // Geometry of the instance under test; the defaults of the package are used.
   localparam int TABLE_DEPTH = ENTRIES_DEF;
   localparam int KEY_BITS    = KEY_BITS_DEF;
   localparam int COUNT_BITS  = COUNT_BITS_DEF;
   localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [63:0] AMOUNT_MAX = (64'd1 << AMOUNT_W) - 64'd1;
   localparam int KEY_POOL_SIZE = 96;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   kct_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kct_rsp_type rsp_payload;

   // Idle rates in percent; the main sequence changes them between phases.
   int send_idle_pct = 24;
   int recv_idle_pct = 63;

   int bad_replies = 0;

   // Replies owed by the block, oldest first.
   kct_rsp_type count_replies_due[$];
   kct_rsp_type due_reply;

   // Shadow copy of the table.
   logic [KEY_BITS-1:0]   slot_key[TABLE_DEPTH];
   logic [COUNT_BITS-1:0] slot_count[TABLE_DEPTH];
   bit                    slot_live[TABLE_DEPTH];

   // Keys that the random traffic draws from. There are more of them than
   // table entries, so the table fills up from time to time.
   logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

   keyed_count_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns the reply that the
   // block must give for it. A lookup hits only valid entries; an insert takes
   // the lowest free entry.
   function automatic kct_rsp_type apply_count_request(kct_req_type item);
      logic [KEY_BITS-1:0] key;
      logic [63:0]         amt;
      logic [63:0]         total;
      logic [63:0]         left;
      int                  hit;
      int                  free_slot;
      bit                  any_live;
      kct_rsp_type         reply;
      key = item.item_key[KEY_BITS-1:0];
      amt = 64'(item.amount);
      hit = -1;
      free_slot = -1;
      left = 64'd0;
      reply.status = ST_OK;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i]) begin
            if (hit < 0 && slot_key[i] == key) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (item.req_type == OP_ADD) begin
         if (hit >= 0) begin
            total = 64'(slot_count[hit]) + amt;
            if (total > COUNT_MAX) begin
               total = COUNT_MAX;
               reply.status = ST_SATURATED;
            end
            slot_count[hit] = total[COUNT_BITS-1:0];
            left = total;
         end else if (free_slot < 0) begin
            reply.status = ST_FULL;
         end else begin
            total = amt;
            if (total > COUNT_MAX) begin
               total = COUNT_MAX;
               reply.status = ST_SATURATED;
            end
            slot_key[free_slot] = key;
            slot_count[free_slot] = total[COUNT_BITS-1:0];
            slot_live[free_slot] = 1'b1;
            left = total;
         end
      end else begin
         if (hit < 0) begin
            reply.status = ST_NOT_FOUND;
         end else if (64'(slot_count[hit]) < amt) begin
            reply.status = ST_NOT_ENOUGH;
            left = 64'(slot_count[hit]);
         end else if (64'(slot_count[hit]) == amt) begin
            slot_live[hit] = 1'b0;
         end else begin
            slot_count[hit] = slot_count[hit] - amt[COUNT_BITS-1:0];
            left = 64'(slot_count[hit]);
         end
      end
      any_live = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) any_live |= slot_live[i];
      reply.count_now = left[OUT_CNT_W-1:0];
      reply.table_empty = !any_live;
      return reply;
   endfunction

   // Looks a key up in the shadow table without changing it.
   function automatic bit find_key(input logic [KEY_W-1:0] key,
                                   output logic [COUNT_BITS-1:0] held);
      held = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i] && slot_key[i] == key[KEY_BITS-1:0]) begin
            held = slot_count[i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int live_entries();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) n += slot_live[i];
      return n;
   endfunction

   // Amounts for an add: mostly small, with full-range values and values
   // close to the maximum so that sums saturate now and then.
   function automatic logic [AMOUNT_W-1:0] add_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return AMOUNT_W'($urandom_range(0, 15));
      else if (roll < 60) return AMOUNT_W'($urandom);
      else if (roll < 75) return AMOUNT_W'(AMOUNT_MAX - $urandom_range(0, 15));
      else return AMOUNT_W'($urandom_range(0, 1000));
   endfunction

   // Amounts for a remove are chosen against the count that the key holds,
   // so that exact deletes, partial removes and shortfalls all occur.
   function automatic logic [AMOUNT_W-1:0] remove_amount(input logic [KEY_W-1:0] key);
      logic [COUNT_BITS-1:0] held_bits;
      logic [63:0]           held;
      logic [63:0]           more;
      int                    roll;
      if (!find_key(key, held_bits)) return AMOUNT_W'($urandom);
      held = 64'(held_bits);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         return AMOUNT_W'(held);
      end else if (roll < 60) begin
         if (held > 64'd8) return AMOUNT_W'(held - $urandom_range(1, 8));
         return AMOUNT_W'($urandom_range(0, int'(held)));
      end else if (roll < 80) begin
         more = held + $urandom_range(1, 8);
         if (more > AMOUNT_MAX) more = held;
         return AMOUNT_W'(more);
      end else if (roll < 90) begin
         return '0;
      end
      return AMOUNT_W'($urandom);
   endfunction

   // Sends one request and records the reply it is owed once the transfer
   // has taken place. Valid is lowered only when the sender idles, so a
   // request that follows directly keeps valid high without a glitch.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic [AMOUNT_W-1:0] amt);
      kct_req_type item;
      item.req_type = op;
      item.item_key = key;
      item.amount = amt;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         // Gaps of varied length land at different points of the table scan.
         repeat ($urandom_range(1, TABLE_DEPTH / 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      count_replies_due.push_back(apply_count_request(item));
   endtask

   // Boundary values of every field, both operations and the corner cases
   // of insert, delete and saturation, starting from an empty table.
   task automatic test_directed_edges();
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_b;
      key_a = 64'h0123_4567_89AB_CDEF;
      key_b = 64'hFEDC_BA98_7654_3210;
      // A remove on an empty table finds nothing.
      send_request(OP_REMOVE, '0, '0);
      // A zero-amount add still creates the entry, and a zero-amount remove
      // of a zero count deletes it again.
      send_request(OP_ADD, '0, '0);
      send_request(OP_REMOVE, '0, '0);
      // The largest key with the largest amount, then saturation.
      send_request(OP_ADD, '1, '1);
      send_request(OP_ADD, '1, AMOUNT_W'(1));
      send_request(OP_ADD, '1, '0);
      send_request(OP_REMOVE, '1, '1);
      // Shortfall, partial remove and zero remove of a nonzero count.
      send_request(OP_ADD, key_a, AMOUNT_W'(100));
      send_request(OP_REMOVE, key_a, AMOUNT_W'(101));
      send_request(OP_REMOVE, key_a, AMOUNT_W'(40));
      send_request(OP_REMOVE, key_a, '0);
      send_request(OP_ADD, key_a, '1);
      // A missing key while the table is not empty.
      send_request(OP_REMOVE, key_b, AMOUNT_W'(5));
      // Alternating bit patterns in key and amount.
      send_request(OP_ADD, {16{4'hA}}, {1'b0, {15{2'b10}}});
      send_request(OP_ADD, {16{4'h5}}, {1'b1, {15{2'b01}}});
      send_request(OP_REMOVE, {16{4'hA}}, {1'b0, {15{2'b10}}});
      send_request(OP_REMOVE, key_a, '1);
      send_request(OP_REMOVE, {16{4'h5}}, AMOUNT_W'(1));
   endtask

   // Fills every entry, probes the full table, frees one entry and refills
   // it, then empties the table with exact removes.
   task automatic test_table_full();
      logic [KEY_W-1:0]      fresh;
      logic [COUNT_BITS-1:0] held;
      while (live_entries() < TABLE_DEPTH) begin
         fresh = {$urandom, $urandom};
         send_request(OP_ADD, fresh, add_amount());
      end
      // A new key finds no room; a present key is still updated.
      send_request(OP_ADD, {$urandom, $urandom}, AMOUNT_W'(7));
      send_request(OP_ADD, slot_key[5], AMOUNT_W'(3));
      send_request(OP_REMOVE, slot_key[10], slot_count[10]);
      // The freed entry is the only free one, so the next insert lands there.
      send_request(OP_ADD, {$urandom, $urandom}, add_amount());
      send_request(OP_ADD, {$urandom, $urandom}, add_amount());
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i]) begin
            // Read the count through the lookup so the remove is exact.
            void'(find_key(slot_key[i], held));
            send_request(OP_REMOVE, slot_key[i], held);
         end
      end
   endtask

   // Mixed traffic over the key pool with some fully random keys as noise.
   task automatic test_random_traffic(input int count);
      logic [KEY_W-1:0] key;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 90) key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         else key = {$urandom, $urandom};
         if ($urandom_range(0, 99) < 55) send_request(OP_ADD, key, add_amount());
         else send_request(OP_REMOVE, key, remove_amount(key));
      end
   endtask

   // The receiver stalls at random, with a fresh draw at each clock edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every reply transfer is compared with the oldest reply owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (count_replies_due.size() == 0) begin
            $display("%0t: reply with none owed: %p", $time, rsp_payload);
            bad_replies++;
         end else begin
            due_reply = count_replies_due.pop_front();
            if (rsp_payload.status !== due_reply.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, due_reply.status, rsp_payload.status);
               bad_replies++;
            end
            if (rsp_payload.count_now !== due_reply.count_now) begin
               $display("%0t: count_now expected %0d actual %0d",
                        $time, due_reply.count_now, rsp_payload.count_now);
               bad_replies++;
            end
            if (rsp_payload.table_empty !== due_reply.table_empty) begin
               $display("%0t: table_empty expected %0d actual %0d",
                        $time, due_reply.table_empty, rsp_payload.table_empty);
               bad_replies++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // First phase: the sender idles a little and the receiver a lot.
      test_directed_edges();
      test_table_full();
      test_random_traffic(300);

      // Second phase: the roles swap.
      send_idle_pct = 63;
      recv_idle_pct = 24;
      test_random_traffic(300);

      // Last phase: neither side idles.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(300);
      req_valid <= 1'b0;

      while (count_replies_due.size() != 0) @(posedge clock);
      // A stray extra reply would still show up while the bench waits on here.
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (bad_replies == 0) begin
         $display("keyed_count_table: match");
      end else begin
         $display("keyed_count_table: mismatch");
      end
      $finish;
   end

   // A correct run takes about a millisecond even with the heaviest stalls.
   initial begin
      #6_000_000;
      $display("keyed_count_table: mismatch");
      $finish;
   end

endmodule
